### rtl/ujse_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ujse_pkg
// Shared types and constants of the UTF-8 JSON string escaper.
// ---------------------------------------------------------------------------
package ujse_pkg;

	localparam int QDEPTH_DEF = 4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// output work for one request: opening quote, replacement runs, then a tail
	typedef struct packed {
		logic            open;
		logic [2:0]      repl;
		logic [2:0]      tail_len;
		logic [5:0][7:0] tail;
	} desc_t;

endpackage
`default_nettype wire

### rtl/utf8_json_string_escaper_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_json_string_escaper_top
// Validates a UTF-8 byte stream and emits it as an escaped, quoted JSON string.
// ---------------------------------------------------------------------------
// channel  dir  tdata                 tuser / tlast
// s_*      in   [7:0] byte_value      tuser: end_of_string
// m_*      out  [7:0] out_byte        tlast: last_of_run
//
// one request is taken per cycle while the descriptor queue has room
// each request yields 0 to 24 output bytes, one per cycle from the serializer while m_tready allows
// a request reaches the output through the descriptor queue and then the output register
// reset clears the decoder state (not its pending byte store), the queue pointers and the output valid flag at once
// output stalls fill the queue; input stalls leave the serializer draining
// ---------------------------------------------------------------------------
module utf8_json_string_escaper_top import ujse_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] byte_value
	input  wire logic       s_tuser,   // [0] end_of_string
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast
);

	desc_t f_desc, q_head;
	logic  f_push, q_not_full, q_not_empty, b_pop;

	assign s_tready = q_not_full;

	ujse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_not_full),
		.push     (f_push),
		.desc     (f_desc)
	);

	ujse_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.din       (f_desc),
		.not_full  (q_not_full),
		.pop       (b_pop),
		.not_empty (q_not_empty),
		.dout      (q_head)
	);

	ujse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (q_head),
		.pop        (b_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

### rtl/ujse_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ujse_front
// Strict UTF-8 decoder; turns each request that yields output into an output descriptor.
// ---------------------------------------------------------------------------
module ujse_front import ujse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tuser,
	input  wire logic       q_ready,
	output logic            push,
	output desc_t           desc
);

	typedef struct packed {
		logic            rep1;
		logic            lead;
		logic [1:0]      need;
		logic [20:0]     cp;
		logic [2:0]      len;
		logic [5:0][7:0] tail;
	} start_t;

	logic             in_string_q, in_string_n;
	logic [2:0][7:0]  pend_q, pend_n;
	logic [1:0]       pcnt_q, pcnt_n;
	logic [1:0]       need_q, need_n;
	logic [20:0]      cp_q, cp_n;
	logic             accept;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		r = (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
		return r;
	endfunction

	function automatic logic [5:0][7:0] u00_tail(input logic [7:0] v);
		logic [5:0][7:0] t;
		t[0] = CH_BSLASH;
		t[1] = CH_U;
		t[2] = CH_ZERO;
		t[3] = CH_ZERO;
		t[4] = hex_char(v[7:4]);
		t[5] = hex_char(v[3:0]);
		return t;
	endfunction

	function automatic start_t start_char(input logic [7:0] c);
		start_t r;
		r = '0;
		if (!c[7]) begin
			if (c == CH_QUOTE || c == CH_BSLASH) begin
				r.len     = 3'd2;
				r.tail[0] = CH_BSLASH;
				r.tail[1] = c;
			end else if (c < 8'h20 || c == 8'h7f) begin
				r.len  = 3'd6;
				r.tail = u00_tail(c);
			end else begin
				r.len     = 3'd1;
				r.tail[0] = c;
			end
		end else if (c >= 8'hc2 && c <= 8'hdf) begin
			r.lead = 1'b1;
			r.need = 2'd1;
			r.cp   = {16'd0, c[4:0]};
		end else if (c >= 8'he0 && c <= 8'hef) begin
			r.lead = 1'b1;
			r.need = 2'd2;
			r.cp   = {17'd0, c[3:0]};
		end else if (c >= 8'hf0 && c <= 8'hf4) begin
			r.lead = 1'b1;
			r.need = 2'd3;
			r.cp   = {18'd0, c[2:0]};
		end else begin
			r.rep1 = 1'b1;
		end
		return r;
	endfunction

	assign accept = s_tvalid && q_ready;

	always_comb begin
		start_t      sc;
		logic [20:0] v;
		logic [1:0]  need_m1;
		logic        bad;
		sc          = '0;
		v           = {cp_q[14:0], s_tdata[5:0]};
		need_m1     = need_q - 2'd1;
		bad         = 1'b0;
		desc        = '0;
		desc.open   = !in_string_q;
		in_string_n = in_string_q;
		pend_n      = pend_q;
		pcnt_n      = pcnt_q;
		need_n      = need_q;
		cp_n        = cp_q;
		if (s_tuser) begin
			desc.repl     = {1'b0, pcnt_q};
			desc.tail_len = 3'd1;
			desc.tail[0]  = CH_QUOTE;
			in_string_n   = 1'b0;
			pcnt_n        = 2'd0;
			need_n        = 2'd0;
			cp_n          = '0;
		end else if (need_q == 2'd0 || s_tdata[7:6] != 2'b10) begin
			in_string_n   = 1'b1;
			sc            = start_char(s_tdata);
			desc.repl     = ((need_q == 2'd0) ? 3'd0 : {1'b0, pcnt_q}) + {2'd0, sc.rep1};
			desc.tail_len = sc.len;
			desc.tail     = sc.tail;
			need_n        = sc.need;
			cp_n          = sc.cp;
			pcnt_n        = sc.lead ? 2'd1 : 2'd0;
			if (sc.lead) begin
				pend_n[0] = s_tdata;
			end
		end else if (need_m1 != 2'd0) begin
			in_string_n    = 1'b1;
			pend_n[pcnt_q] = s_tdata;
			pcnt_n         = pcnt_q + 2'd1;
			need_n         = need_m1;
			cp_n           = v;
		end else begin
			in_string_n = 1'b1;
			bad = (pcnt_q == 2'd2 && v < 21'h000800) ||
			      (pcnt_q == 2'd3 && v < 21'h010000) ||
			      (v >= 21'h00d800 && v <= 21'h00dfff) ||
			      (v > 21'h10ffff);
			if (bad) begin
				desc.repl = {1'b0, pcnt_q} + 3'd1;
			end else if (v <= 21'h00009f) begin
				desc.tail_len = 3'd6;
				desc.tail     = u00_tail(v[7:0]);
			end else begin
				desc.tail[0]      = pend_q[0];
				desc.tail[1]      = pend_q[1];
				desc.tail[2]      = pend_q[2];
				desc.tail[pcnt_q] = s_tdata;
				desc.tail_len     = {1'b0, pcnt_q} + 3'd1;
			end
			pcnt_n = 2'd0;
			need_n = 2'd0;
			cp_n   = '0;
		end
		push = accept && (desc.open || desc.repl != 3'd0 || desc.tail_len != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			pcnt_q      <= 2'd0;
			need_q      <= 2'd0;
			cp_q        <= '0;
		end else if (accept) begin
			in_string_q <= in_string_n;
			pcnt_q      <= pcnt_n;
			need_q      <= need_n;
			cp_q        <= cp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= pend_n;
		end
	end

endmodule
`default_nettype wire

### rtl/ujse_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ujse_fifo
// Short descriptor queue between decoder and serializer.
// ---------------------------------------------------------------------------
module ujse_fifo import ujse_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t din,
	output logic       not_full,
	input  wire logic  pop,
	output logic       not_empty,
	output desc_t      dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign not_full  = cnt_q != CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign dout      = mem_q[rd_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

### rtl/ujse_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ujse_back
// Serializer: walks one descriptor byte by byte into the output register.
// ---------------------------------------------------------------------------
module ujse_back import ujse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire desc_t      head,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	logic       open_done_q;
	logic [2:0] rep_q;
	logic [2:0] sub_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load, step, in_open, in_repl, last;
	logic [7:0] cur;

	function automatic logic [7:0] repl_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0:    r = CH_BSLASH;
			3'd1:    r = CH_U;
			3'd5:    r = 8'h64;
			default: r = 8'h66;
		endcase
		return r;
	endfunction

	assign load    = !out_valid_q || m_tready;
	assign step    = head_valid && load;
	assign in_open = head.open && !open_done_q;
	assign in_repl = !in_open && (rep_q < head.repl);

	always_comb begin
		if (in_open) begin
			cur  = CH_QUOTE;
			last = (head.repl == 3'd0) && (head.tail_len == 3'd0);
		end else if (in_repl) begin
			cur  = repl_char(sub_q);
			last = (sub_q == 3'd5) && (rep_q + 3'd1 == head.repl) && (head.tail_len == 3'd0);
		end else begin
			cur  = head.tail[sub_q];
			last = (sub_q + 3'd1 == head.tail_len);
		end
	end

	assign pop = step && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_done_q <= 1'b0;
			rep_q       <= 3'd0;
			sub_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				if (last) begin
					open_done_q <= 1'b0;
					rep_q       <= 3'd0;
					sub_q       <= 3'd0;
				end else if (in_open) begin
					open_done_q <= 1'b1;
				end else if (in_repl && sub_q == 3'd5) begin
					sub_q <= 3'd0;
					rep_q <= rep_q + 3'd1;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
			if (load) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= cur;
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

### rtl/ujse_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ujse_checker
// Port-level checks of the escaper, bound to the top level.
// ---------------------------------------------------------------------------
module ujse_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			seen_q <= 1'b1;
		end
	end

	// nothing comes out of reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid right after reset");

	// no output before any request was taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q)
		else $error("output without any request");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed under stall");

endmodule

bind utf8_json_string_escaper_top ujse_checker u_ujse_checker (.*);
`default_nettype wire

### tb/utf8_json_string_escaper_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_json_string_escaper_top_test
// Streams byte requests and end markers into the escaper and checks every
// output byte and its tlast against an in-bench UTF-8 decoder and JSON
// escaper. A short directed list covers the corner cases. Random strings,
// mostly well-formed UTF-8 with broken and out-of-range forms mixed in, then
// run under changing idle patterns; control and ff bytes see an output stall.
// ---------------------------------------------------------------------------
module utf8_json_string_escaper_top_test;
	import ujse_pkg::*;

	localparam int MAX_CYCLES   = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX   = 10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] LEAD2_LO = 8'hc2;
	localparam logic [7:0] LEAD2_HI = 8'hdf;
	localparam logic [7:0] LEAD3_LO = 8'he0;
	localparam logic [7:0] LEAD3_HI = 8'hef;
	localparam logic [7:0] LEAD4_LO = 8'hf0;
	localparam logic [7:0] LEAD4_HI = 8'hf4;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} json_char_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] byte_value
	logic       s_tuser  = 1'b0;    // [0] end_of_string
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tlast;            // last_of_run

	utf8_json_string_escaper_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// escaper state
	json_char_t  json_q[$];
	json_char_t  step_q[$];
	bit          str_open;
	logic [7:0]  held [3];
	int          held_n;
	int          cont_left;
	logic [20:0] scalar;

	int          tx_idle;
	int          rx_idle;
	bit          hold_req;
	int          hold_left;
	int          errors;
	int          reqs_sent;
	int unsigned cycles;
	logic [7:0]  seq_q[$];

	function automatic void put_ch(input logic [7:0] ch);
		json_char_t c;
		c.ch = ch;
		c.last = 1'b0;
		step_q.push_back(c);
	endfunction

	function automatic void put_fffd();
		put_ch(CH_BSLASH);
		put_ch(CH_U);
		put_ch(CH_F);
		put_ch(CH_F);
		put_ch(CH_F);
		put_ch(CH_D);
	endfunction

	function automatic logic [7:0] hex_ch(input logic [3:0] n);
		return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_A + 8'(n - 4'd10);
	endfunction

	function automatic void put_u00(input logic [7:0] v);
		put_ch(CH_BSLASH);
		put_ch(CH_U);
		put_ch(CH_ZERO);
		put_ch(CH_ZERO);
		put_ch(hex_ch(v[7:4]));
		put_ch(hex_ch(v[3:0]));
	endfunction

	function automatic void drop_seq();
		held_n = 0;
		cont_left = 0;
		scalar = '0;
	endfunction

	function automatic void flush_held();
		repeat (held_n) put_fffd();
		drop_seq();
	endfunction

	function automatic void start_char(input logic [7:0] c);
		if (!c[7]) begin
			if (c == CH_QUOTE || c == CH_BSLASH) begin
				put_ch(CH_BSLASH);
				put_ch(c);
			end else if (c < CH_SPACE || c == CH_DEL) begin
				put_u00(c);
			end else begin
				put_ch(c);
			end
			return;
		end
		if (c >= LEAD2_LO && c <= LEAD2_HI) begin
			cont_left = 1;
			scalar = 21'(c[4:0]);
		end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
			cont_left = 2;
			scalar = 21'(c[3:0]);
		end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
			cont_left = 3;
			scalar = 21'(c[2:0]);
		end else begin
			put_fffd();
			return;
		end
		held[0] = c;
		held_n = 1;
	endfunction

	function automatic void take_byte(input logic [7:0] c);
		logic [20:0] v;
		bit          bad;
		int          i;
		if (cont_left == 0) begin
			start_char(c);
		end else if (c[7:6] != 2'b10) begin
			flush_held();
			start_char(c);
		end else begin
			v = {scalar[14:0], c[5:0]};
			scalar = v;
			cont_left--;
			if (cont_left != 0) begin
				if (held_n < 3) begin
					held[held_n] = c;
					held_n++;
				end
			end else begin
				bad = (held_n == 2 && v < 21'h800) || (held_n == 3 && v < 21'h10000) ||
					(v >= 21'hd800 && v <= 21'hdfff) || (v > 21'h10ffff);
				if (bad) begin
					repeat (held_n + 1) put_fffd();
				end else if (v <= 21'h9f) begin
					put_u00(v[7:0]);
				end else begin
					for (i = 0; i < held_n; i++)
						put_ch(held[i]);
					put_ch(c);
				end
				drop_seq();
			end
		end
	endfunction

	function automatic void escape_step(input logic [7:0] b, input logic eos);
		json_char_t tail;
		step_q.delete();
		if (!str_open) begin
			put_ch(CH_QUOTE);
			str_open = 1'b1;
		end
		if (eos) begin
			flush_held();
			put_ch(CH_QUOTE);
			str_open = 1'b0;
		end else begin
			take_byte(b);
		end
		if (step_q.size() != 0) begin
			tail = step_q.pop_back();
			tail.last = 1'b1;
			step_q.push_back(tail);
		end
		foreach (step_q[i])
			json_q.push_back(step_q[i]);
	endfunction

	// utf-8 encoding of cp in exactly len bytes, overlong forms included
	function automatic void encode(input logic [20:0] cp, input int len);
		seq_q.delete();
		case (len)
		1: seq_q.push_back({1'b0, cp[6:0]});
		2: begin
			seq_q.push_back({3'b110, cp[10:6]});
			seq_q.push_back({2'b10, cp[5:0]});
		end
		3: begin
			seq_q.push_back({4'b1110, cp[15:12]});
			seq_q.push_back({2'b10, cp[11:6]});
			seq_q.push_back({2'b10, cp[5:0]});
		end
		default: begin
			seq_q.push_back({5'b11110, cp[20:18]});
			seq_q.push_back({2'b10, cp[17:12]});
			seq_q.push_back({2'b10, cp[11:6]});
			seq_q.push_back({2'b10, cp[5:0]});
		end
		endcase
	endfunction

	function automatic logic [20:0] valid_cp(input int len);
		case (len)
		1: return 21'($urandom_range(127));
		2: return 21'($urandom_range(2047, 128));
		3: return 21'($urandom_range(65535, 2048));
		default: return 21'($urandom_range(21'h10ffff, 21'h10000));
		endcase
	endfunction

	function automatic void note_error(input string what, input logic [7:0] want,
		input logic [7:0] got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		escape_step(b, eos);
		reqs_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq();
		int i;
		for (i = 0; i < seq_q.size(); i++)
			send_req(seq_q[i], 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (json_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_idle(input int tx, input int rx);
		@(posedge clk);
		tx_idle = tx;
		rx_idle = rx;
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_req(8'hff, 1'b1);   // empty string, byte ignored
		send_req(8'h00, 1'b0);
		send_req(8'h1f, 1'b0);
		send_req(CH_QUOTE, 1'b0);
		send_req(CH_BSLASH, 1'b0);
		send_req(CH_DEL, 1'b0);
		send_req(8'hc2, 1'b0);   // c1 control
		send_req(8'h9f, 1'b0);
		send_req(8'hed, 1'b0);   // surrogate
		send_req(8'ha0, 1'b0);
		send_req(8'h80, 1'b0);
		send_req(8'hf4, 1'b0);   // above 10ffff
		send_req(8'h90, 1'b0);
		send_req(8'h80, 1'b0);
		send_req(8'h80, 1'b0);
		send_req(8'he2, 1'b0);   // broken by an ascii byte
		send_req(8'h41, 1'b0);
		send_req(8'hf0, 1'b0);   // end with a sequence pending
		send_req(8'h9f, 1'b0);
		send_req(8'h00, 1'b1);
		send_req(8'hff, 1'b0);   // invalid lead opens a string
		send_req(8'h7e, 1'b1);
		wait_drained();
	endtask

	task automatic test_random(input int n);
		int          stop_at;
		int          pick;
		int          len;
		logic [20:0] cp;
		stop_at = reqs_sent + n;
		while (reqs_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_req(8'($urandom), 1'b1);
			end else if (pick < 18) begin
				send_req(8'($urandom), 1'b0);
			end else begin
				if (pick < 70) begin
					len = $urandom_range(4, 1);
					cp = valid_cp(len);
				end else if (pick < 85) begin
					// overlong, surrogate or above range
					case ($urandom_range(2))
					0: begin
						len = $urandom_range(4, 3);
						cp = valid_cp(len - 1);
					end
					1: begin
						len = 3;
						cp = 21'($urandom_range(16'hdfff, 16'hd800));
					end
					default: begin
						len = 4;
						cp = 21'($urandom_range(21'h1fffff, 21'h110000));
					end
					endcase
				end else begin
					len = $urandom_range(4, 2);
					cp = valid_cp(len);
				end
				encode(cp, len);
				if (pick >= 85) begin
					// truncated sequence
					pick = $urandom_range(len - 1, 1);
					while (seq_q.size() > pick)
						void'(seq_q.pop_back());
				end
				send_seq();
			end
		end
		wait_drained();
	endtask

	task automatic test_stall();
		int i;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		for (i = 0; i < 30; i++)
			send_req(($urandom_range(1) != 0) ? 8'($urandom_range(31)) : 8'hff, 1'b0);
		send_req(8'h00, 1'b1);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin : check_out
		json_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (json_q.size() == 0) begin
				note_error("unexpected byte", 8'h00, m_tdata);
			end else begin
				want = json_q.pop_front();
				if (m_tdata !== want.ch)
					note_error("out_byte", want.ch, m_tdata);
				if (m_tlast !== want.last)
					note_error("last_of_run", 8'(want.last), 8'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == MAX_CYCLES) begin
			$display("[utf8_json_string_escaper_top] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_idle(15, 46);
		test_directed();
		test_random(80);
		set_idle(0, 0);
		test_stall();
		set_idle(46, 15);
		test_random(80);
		set_idle(0, 0);
		test_random(80);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && json_q.size() == 0) begin
			$display("[utf8_json_string_escaper_top] OK");
		end else begin
			$display("[utf8_json_string_escaper_top] ERROR");
		end
		$finish;
	end

endmodule
